@@ hw/rtl/fsrc_pkg.sv @@
// Constants, widths and sequencer codes for the frame size rate controller.
package fsrc_pkg;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 49;

   localparam logic [16:0] SCALE_ONE = 17'd4096;
   localparam logic [16:0] SCALE_MIN = 17'd1024;
   localparam logic [16:0] SCALE_MAX = 17'd65536;
   localparam logic [12:0] STEP_MIN  = 13'd3482;
   localparam logic [12:0] STEP_MAX  = 13'd4915;
   localparam logic [30:0] ROUND_HALF = 31'd2048;
   localparam logic [31:0] SMOOTH_DIV = 32'd10;

   // iteration counts, loaded as count minus one
   localparam logic [5:0] DIV_AVG_LAST   = 6'd43;
   localparam logic [5:0] DIV_RATIO_LAST = 6'd55;
   localparam logic [5:0] ROOT_LAST      = 6'd16;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL7  = 4'd1;
   localparam logic [3:0] ST_ADD2  = 4'd2;
   localparam logic [3:0] ST_ADD1  = 4'd3;
   localparam logic [3:0] ST_DAVG  = 4'd4;
   localparam logic [3:0] ST_LDRAT = 4'd5;
   localparam logic [3:0] ST_DRAT  = 4'd6;
   localparam logic [3:0] ST_CAP   = 4'd7;
   localparam logic [3:0] ST_ROOT  = 4'd8;
   localparam logic [3:0] ST_MULT  = 4'd9;
   localparam logic [3:0] ST_CLAMP = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

endpackage

@@ hw/rtl/frame_size_rate_controller.sv @@
// Counted frames pass the 0.7/0.3 average (not the first after reset or a nonzero target write), the
// average/target divide, the root, multiply and clamp; other beats go straight to the output.
// A new beat is taken only in idle, once the result is registered; the bit-serial divider
// (44 steps for the 0.7/0.3 average, 56 for average/target) and the 17-step root set the rate.
// Reset (synchronous, active high): target 0 (control off), scale 1.0, average 0,
// no frame seen, output empty.
module frame_size_rate_controller
   import fsrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] encoded_bytes
   input  logic                   req_tuser,   // [0] encode_ok
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [16:0] quant_scale, [48:17] average_bytes, rest 0
   output logic                   rsp_tuser,   // [0] control_enabled
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [31:0]            csr_wdata    // target_frame_bytes
);

   logic [3:0]  state_ff,  state_in;
   logic [31:0] target_ff, target_in;
   logic [39:0] smooth_ff, smooth_in;
   logic [16:0] scale_ff,  scale_in;
   logic        warmed_ff, warmed_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] bytes_ff,  bytes_in;
   logic [43:0] acc_ff,    acc_in;
   logic [55:0] divd_ff,   divd_in;
   logic [31:0] rem_ff,    rem_in;
   logic [55:0] quo_ff,    quo_in;
   logic [5:0]  cnt_ff,    cnt_in;
   logic [33:0] rad_ff,    rad_in;
   logic [17:0] srem_ff,   srem_in;
   logic [16:0] root_ff,   root_in;
   logic [30:0] prod_ff,   prod_in;
   logic [16:0] rsp_scale_ff, rsp_scale_in;
   logic [31:0] rsp_avg_ff,   rsp_avg_in;
   logic        rsp_en_ff,    rsp_en_in;

   logic        req_take;
   logic        out_free;
   logic [31:0] dsr;
   logic [32:0] rem_sh;
   logic [32:0] rem_diff;
   logic        div_ge;
   logic [55:0] quo_step;
   logic [19:0] root_sh;
   logic [19:0] root_trial;
   logic [19:0] root_diff;
   logic        root_ge;
   logic [12:0] step;
   logic [18:0] prod_q;

   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_avg_ff, rsp_scale_ff};
   assign rsp_tuser  = rsp_en_ff;

   // one restoring divide step, shared by both divisions
   assign dsr      = (state_ff == ST_DAVG) ? SMOOTH_DIV : target_ff;
   assign rem_sh   = {rem_ff, divd_ff[55]};
   assign rem_diff = rem_sh - {1'b0, dsr};
   assign div_ge   = (rem_sh >= {1'b0, dsr});
   assign quo_step = {quo_ff[54:0], div_ge};

   // one two-bit square root step
   assign root_sh    = {srem_ff, rad_ff[33:32]};
   assign root_trial = {1'b0, root_ff, 2'b01};
   assign root_diff  = root_sh - root_trial;
   assign root_ge    = (root_sh >= root_trial);

   always_comb begin
      if (root_ff < {4'b0, STEP_MIN}) begin
         step = STEP_MIN;
      end else if (root_ff > {4'b0, STEP_MAX}) begin
         step = STEP_MAX;
      end else begin
         step = root_ff[12:0];
      end
   end

   assign prod_q = prod_ff[30:12];

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      smooth_in    = smooth_ff;
      scale_in     = scale_ff;
      warmed_in    = warmed_ff;
      rsp_valid_in = rsp_valid_ff;
      bytes_in     = bytes_ff;
      acc_in       = acc_ff;
      divd_in      = divd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      prod_in      = prod_ff;
      rsp_scale_in = rsp_scale_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_en_in    = rsp_en_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               target_in = csr_wdata;
               if (csr_wdata != 32'd0) begin
                  scale_in  = SCALE_ONE;
                  smooth_in = 40'd0;
                  warmed_in = 1'b0;
               end
            end else if (req_take) begin
               bytes_in = req_tdata;
               if (target_ff != 32'd0 && req_tuser && req_tdata != 32'd0) begin
                  if (warmed_ff) begin
                     state_in = ST_MUL7;
                  end else begin
                     // first frame loads the average directly
                     smooth_in = {req_tdata, 8'd0};
                     warmed_in = 1'b1;
                     state_in  = ST_LDRAT;
                  end
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_MUL7: begin
            acc_in   = {1'b0, smooth_ff, 3'd0} - {4'd0, smooth_ff};
            state_in = ST_ADD2;
         end
         ST_ADD2: begin
            acc_in   = acc_ff + {3'd0, bytes_ff, 9'd0};
            state_in = ST_ADD1;
         end
         ST_ADD1: begin
            // fresh plus the rounding constant 5: low byte of fresh is zero
            divd_in  = {acc_ff + {4'd0, bytes_ff, 8'd5}, 12'd0};
            rem_in   = 32'd0;
            quo_in   = 56'd0;
            cnt_in   = DIV_AVG_LAST;
            state_in = ST_DAVG;
         end
         ST_DAVG: begin
            divd_in = {divd_ff[54:0], 1'b0};
            rem_in  = div_ge ? rem_diff[31:0] : rem_sh[31:0];
            quo_in  = quo_step;
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               smooth_in = quo_step[39:0];
               state_in  = ST_LDRAT;
            end
         end
         ST_LDRAT: begin
            divd_in  = {smooth_ff, 16'd0};
            rem_in   = 32'd0;
            quo_in   = 56'd0;
            cnt_in   = DIV_RATIO_LAST;
            state_in = ST_DRAT;
         end
         ST_DRAT: begin
            divd_in = {divd_ff[54:0], 1'b0};
            rem_in  = div_ge ? rem_diff[31:0] : rem_sh[31:0];
            quo_in  = quo_step;
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = ST_CAP;
            end
         end
         ST_CAP: begin
            // cap the ratio at 2^32
            if ((quo_ff[55:33] != 23'd0) || (quo_ff[32] && quo_ff[31:0] != 32'd0)) begin
               rad_in = {2'b01, 32'd0};
            end else begin
               rad_in = {1'b0, quo_ff[32:0]};
            end
            srem_in  = 18'd0;
            root_in  = 17'd0;
            cnt_in   = ROOT_LAST;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[31:0], 2'b00};
            srem_in = root_ge ? root_diff[17:0] : root_sh[17:0];
            root_in = {root_ff[15:0], root_ge};
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_in  = ({14'd0, scale_ff} * {18'd0, step}) + ROUND_HALF;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (prod_q < {2'b0, SCALE_MIN}) begin
               scale_in = SCALE_MIN;
            end else if (prod_q > {2'b0, SCALE_MAX}) begin
               scale_in = SCALE_MAX;
            end else begin
               scale_in = prod_q[16:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_scale_in = scale_ff;
               rsp_avg_in   = smooth_ff[39:8];
               rsp_en_in    = (target_ff != 32'd0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= 32'd0;
         smooth_ff    <= 40'd0;
         scale_ff     <= SCALE_ONE;
         warmed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         smooth_ff    <= smooth_in;
         scale_ff     <= scale_in;
         warmed_ff    <= warmed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff     <= bytes_in;
      acc_ff       <= acc_in;
      divd_ff      <= divd_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      rad_ff       <= rad_in;
      srem_ff      <= srem_in;
      root_ff      <= root_in;
      prod_ff      <= prod_in;
      rsp_scale_ff <= rsp_scale_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_en_ff    <= rsp_en_in;
   end

endmodule
